// ===== src/otd_pkg.sv =====
// ----------------------------------------------------------------------------
// otd_pkg
// Types and codes shared by the entry record decoder.
// ----------------------------------------------------------------------------
package otd_pkg;

  localparam logic [2:0] KIND_KEY   = 3'd0;
  localparam logic [2:0] KIND_VALUE = 3'd1;
  localparam logic [2:0] KIND_ATTR  = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  localparam logic [7:0] NON_ASCII_CHAR = 8'h3F;  // '?'
  localparam logic [7:0] ASCII_LIMIT    = 8'h80;

  localparam logic [3:0] ATTR_A_BASE = 4'd0;
  localparam logic [3:0] ATTR_B_BASE = 4'd2;
  localparam logic [3:0] ATTR_C_BASE = 4'd10;

  localparam logic [31:0] ATTR_A_LEN = 32'd2;
  localparam logic [31:0] ATTR_B_LEN = 32'd8;
  localparam logic [31:0] ATTR_C_LEN = 32'd3;
  localparam logic [31:0] MIN_RAW_LEN = 32'd2;

  typedef enum logic [8:0] {
    PH_KEYLEN = 9'b000000001,
    PH_ATTR_A = 9'b000000010,
    PH_KEYOFF = 9'b000000100,
    PH_KEY    = 9'b000001000,
    PH_ATTR_B = 9'b000010000,
    PH_LEN    = 9'b000100000,
    PH_ATTR_C = 9'b001000000,
    PH_VALUE  = 9'b010000000,
    PH_TRAIL  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [3:0]  attr_index;
    logic [7:0]  key_len_out;
    logic [30:0] value_chars;
  } result_t;

endpackage

// ===== src/otd_parser.sv =====
// ----------------------------------------------------------------------------
// otd_parser
// Record parse state and the per-byte decode; state moves on each transfer.
// ----------------------------------------------------------------------------
module otd_parser
  import otd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [7:0]  key_len_r, key_len_nxt;
  logic [7:0]  key_shift_r, key_shift_nxt;
  logic [31:0] vbytes_r, vbytes_nxt;
  logic [7:0]  vshift_r, vshift_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        halted_r, halted_nxt;

  logic [31:0] cnt_plus;
  logic [31:0] raw_len;
  logic [7:0]  shift_eff;
  logic [7:0]  lo_char;
  logic [7:0]  hi_char;

  assign cnt_plus  = cnt_r + 32'd1;
  assign raw_len   = {data_byte, vbytes_r[23:0]};
  // the second byte of the value sets the shift for its own pair
  assign shift_eff = (cnt_r == 32'd1) ? (8'd0 - data_byte) : vshift_r;
  assign lo_char   = low_byte_r + shift_eff;
  assign hi_char   = data_byte + shift_eff;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    key_len_nxt   = key_len_r;
    key_shift_nxt = key_shift_r;
    vbytes_nxt    = vbytes_r;
    vshift_nxt    = vshift_r;
    low_byte_nxt  = low_byte_r;
    halted_nxt    = halted_r;
    res_valid     = 1'b0;
    res           = '0;
    if (!halted_r) begin
      case (phase_r)
        PH_KEYLEN: begin
          key_len_nxt = data_byte;
          cnt_nxt     = '0;
          phase_nxt   = PH_ATTR_A;
        end
        PH_ATTR_A: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ATTR;
          res.char_code  = data_byte;
          res.attr_index = ATTR_A_BASE + cnt_r[3:0];
          cnt_nxt        = cnt_plus;
          if (cnt_plus >= ATTR_A_LEN) begin
            cnt_nxt   = '0;
            phase_nxt = PH_KEYOFF;
          end
        end
        PH_KEYOFF: begin
          key_shift_nxt = data_byte;
          cnt_nxt       = '0;
          phase_nxt     = (key_len_r != 8'd0) ? PH_KEY : PH_ATTR_B;
        end
        PH_KEY: begin
          res_valid     = 1'b1;
          res.kind      = KIND_KEY;
          res.char_code = data_byte + key_shift_r;
          cnt_nxt       = cnt_plus;
          if (cnt_plus >= {24'd0, key_len_r}) begin
            cnt_nxt   = '0;
            phase_nxt = PH_ATTR_B;
          end
        end
        PH_ATTR_B: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ATTR;
          res.char_code  = data_byte;
          res.attr_index = ATTR_B_BASE + cnt_r[3:0];
          cnt_nxt        = cnt_plus;
          if (cnt_plus >= ATTR_B_LEN) begin
            cnt_nxt    = '0;
            vbytes_nxt = '0;
            phase_nxt  = PH_LEN;
          end
        end
        PH_LEN: begin
          cnt_nxt = cnt_plus;
          case (cnt_r[1:0])
            2'd0: vbytes_nxt[7:0]   = data_byte;
            2'd1: vbytes_nxt[15:8]  = data_byte;
            2'd2: vbytes_nxt[23:16] = data_byte;
            default: begin
              cnt_nxt = '0;
              if (raw_len < MIN_RAW_LEN) begin
                vbytes_nxt = raw_len;
                halted_nxt = 1'b1;
                res_valid  = 1'b1;
                res.kind   = KIND_ERROR;
              end else begin
                vbytes_nxt = raw_len - MIN_RAW_LEN;
                phase_nxt  = PH_ATTR_C;
              end
            end
          endcase
        end
        PH_ATTR_C: begin
          res_valid      = 1'b1;
          res.kind       = KIND_ATTR;
          res.char_code  = data_byte;
          res.attr_index = ATTR_C_BASE + cnt_r[3:0];
          cnt_nxt        = cnt_plus;
          if (cnt_plus >= ATTR_C_LEN) begin
            cnt_nxt    = '0;
            vshift_nxt = '0;
            phase_nxt  = (vbytes_r != 32'd0) ? PH_VALUE : PH_TRAIL;
          end
        end
        PH_VALUE: begin
          if (!cnt_r[0]) begin
            low_byte_nxt = data_byte;
          end else begin
            vshift_nxt    = shift_eff;
            res_valid     = 1'b1;
            res.kind      = KIND_VALUE;
            res.char_code = (hi_char == 8'd0 && lo_char < ASCII_LIMIT) ?
                            lo_char : NON_ASCII_CHAR;
          end
          cnt_nxt = cnt_plus;
          if (cnt_plus >= vbytes_r) begin
            cnt_nxt   = '0;
            phase_nxt = PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          if (cnt_r == 32'd0) begin
            cnt_nxt = 32'd1;
          end else begin
            cnt_nxt         = '0;
            phase_nxt       = PH_KEYLEN;
            res_valid       = 1'b1;
            res.kind        = KIND_END;
            res.key_len_out = key_len_r;
            res.value_chars = vbytes_r[31:1];
          end
        end
        default: begin
          phase_nxt = PH_KEYLEN;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEYLEN;
      cnt_r       <= '0;
      key_len_r   <= '0;
      key_shift_r <= '0;
      vbytes_r    <= '0;
      vshift_r    <= '0;
      low_byte_r  <= '0;
      halted_r    <= 1'b0;
    end else if (go) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      key_len_r   <= key_len_nxt;
      key_shift_r <= key_shift_nxt;
      vbytes_r    <= vbytes_nxt;
      vshift_r    <= vshift_nxt;
      low_byte_r  <= low_byte_nxt;
      halted_r    <= halted_nxt;
    end
  end

endmodule

// ===== src/otd_out_reg.sv =====
// ----------------------------------------------------------------------------
// otd_out_reg
// Result register holding one decoded item until the output transfer.
// ----------------------------------------------------------------------------
module otd_out_reg
  import otd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// ===== src/obfuscated_text_entry_decoder.sv =====
// ----------------------------------------------------------------------------
// obfuscated_text_entry_decoder
// Decodes a stream of key/value entry records, one byte per transfer.
//
//   channel | direction | signals
//   --------+-----------+------------------------------------------------
//   in      | input     | in_valid, in_ready, in_data_byte
//   out     | output    | out_valid, out_ready, out_kind, out_char_code,
//           |           | out_attr_index, out_key_len_out, out_value_chars
//
// One byte per cycle sustained while the output is not stalled. A byte is
// held in the input register, decoded there against the parse state and,
// if it yields a result, registered in the result register. The input register
// keeps taking a byte while a result waits; it holds only when the result
// register is full and out_ready is low. Synchronous reset clears the parse
// state, including the halt after a short raw length.
// ----------------------------------------------------------------------------
module obfuscated_text_entry_decoder
  import otd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_char_code,
  output logic [3:0]  out_attr_index,
  output logic [7:0]  out_key_len_out,
  output logic [30:0] out_value_chars
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       go;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // decode step fires when the input register holds a byte and the result register can take its output
  assign go       = in_valid_r && (!out_valid || out_ready);
  assign in_ready = !in_valid_r || go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  otd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .data_byte (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  otd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && res_valid),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_char_code   = out_res.char_code;
  assign out_attr_index  = out_res.attr_index;
  assign out_key_len_out = out_res.key_len_out;
  assign out_value_chars = out_res.value_chars;

endmodule

// ===== src/otd_checker.sv =====
// ----------------------------------------------------------------------------
// otd_checker
// Port-level checks on the entry record decoder, bound to the top level.
// ----------------------------------------------------------------------------
module otd_checker
  import otd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [7:0]  out_char_code,
  input logic [3:0]  out_attr_index,
  input logic [7:0]  out_key_len_out,
  input logic [30:0] out_value_chars
);

  // a stalled result holds its kind, char code and attribute index
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_char_code) && $stable(out_attr_index))
    else $error("result changed while stalled");

  a_attr_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_ATTR |-> out_attr_index == 4'd0)
    else $error("attribute index set on non-attribute result");

  a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_END |->
    out_key_len_out == 8'd0 && out_value_chars == 31'd0)
    else $error("entry end fields set on other result");

  // halt after error: the result register drains and stays empty
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_ERROR |=> !out_valid)
    else $error("result after error");

endmodule

bind obfuscated_text_entry_decoder otd_checker u_otd_checker (.*);
